@@ hw/rtl/ftlex_pkg.sv @@
`timescale 1ns / 1ps

package ftlex_pkg;

    localparam int CHAR_W      = 8;
    localparam int KIND_W      = 3;
    localparam int TOKEN_VAL_W = 31;
    localparam int COL_W       = 19;
    localparam int OPC_W       = 3;
    localparam int LCOUNT_W    = 4;

    localparam int DEF_MAX_COL_LETTERS = 4;
    localparam int DEF_VALUE_BITS      = 31;

    // Result queue depth; one request may push two tokens.
    localparam int RESULT_DEPTH = 4;

    localparam logic [KIND_W-1:0] KIND_CELL = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INT  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_OPER = 3'd2;
    localparam logic [KIND_W-1:0] KIND_END  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ERR  = 3'd4;

    localparam logic [OPC_W-1:0] OPC_PLUS  = 3'd0;
    localparam logic [OPC_W-1:0] OPC_MINUS = 3'd1;
    localparam logic [OPC_W-1:0] OPC_TIMES = 3'd2;
    localparam logic [OPC_W-1:0] OPC_DIV   = 3'd3;
    localparam logic [OPC_W-1:0] OPC_OPEN  = 3'd4;
    localparam logic [OPC_W-1:0] OPC_CLOSE = 3'd5;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              restart;
    } char_req_t;

    typedef struct packed {
        logic [KIND_W-1:0]      token_kind;
        logic [TOKEN_VAL_W-1:0] token_value;
        logic [COL_W-1:0]       column_number;
        logic [OPC_W-1:0]       operator_code;
        logic                   last;
    } token_req_t;

    // Tokens produced by one character, in order; count is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] count;
        token_req_t first;
        token_req_t second;
    } token_push_t;

endpackage

@@ hw/rtl/formula_token_lexer_top.sv @@
`timescale 1ns / 1ps

// Formula lexer: takes one character request per cycle while char_stall is
// low, and returns tokens (integers, cell references, operators, end, error).
// A character is held in an input register and handled by the lexer state
// logic once the queue has room; it pushes zero, one or two tokens into a
// four-entry result queue. The block takes a new character every cycle while
// the queue has room for two tokens; a character that completes two tokens
// pushes both at once. An integer, cell or operator token is emitted when the
// character after it arrives, an end or error token by its own character, and
// last marks the final token caused by one character.
module formula_token_lexer_top #(
    parameter int MAX_COL_LETTERS = ftlex_pkg::DEF_MAX_COL_LETTERS,
    parameter int VALUE_BITS      = ftlex_pkg::DEF_VALUE_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   char_valid,
    output logic                   char_stall,
    input  ftlex_pkg::char_req_t   char_req,
    output logic                   token_valid,
    input  logic                   token_stall,
    output ftlex_pkg::token_req_t  token_req
);

    logic                   hold_valid_reg, hold_valid_next;
    ftlex_pkg::char_req_t   hold_req_reg;
    logic                   room;
    logic                   step;
    logic                   accept;
    ftlex_pkg::token_push_t push;

    assign step       = hold_valid_reg && room;
    assign char_stall = hold_valid_reg && !room;
    assign accept     = char_valid && !char_stall;

    always_comb
    begin
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (step)
        begin
            hold_valid_next = 1'b0;
        end
        else
        begin
            hold_valid_next = hold_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_req_reg <= char_req;
        end
    end

    ftlex_core #(
        .MAX_COL_LETTERS (MAX_COL_LETTERS),
        .VALUE_BITS      (VALUE_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .req   (hold_req_reg),
        .push  (push)
    );

    ftlex_fifo u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .room        (room),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_req   (token_req)
    );

endmodule

@@ hw/rtl/ftlex_core.sv @@
`timescale 1ns / 1ps

module ftlex_core #(
    parameter int MAX_COL_LETTERS = ftlex_pkg::DEF_MAX_COL_LETTERS,
    parameter int VALUE_BITS      = ftlex_pkg::DEF_VALUE_BITS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  ftlex_pkg::char_req_t    req,
    output ftlex_pkg::token_push_t  push
);

    typedef enum logic [2:0] {
        MODE_START,
        MODE_NUMBER,
        MODE_LETTERS,
        MODE_ROW,
        MODE_OPER,
        MODE_DONE
    } mode_t;

    typedef enum logic [2:0] {
        CLS_LETTER,
        CLS_DIGIT,
        CLS_OPER,
        CLS_SPACE,
        CLS_ZERO,
        CLS_OTHER
    } cls_t;

    localparam int COL_W = ftlex_pkg::COL_W;
    localparam int LCW   = ftlex_pkg::LCOUNT_W;

    mode_t                   mode_reg, mode_next;
    logic [VALUE_BITS-1:0]   acc_reg, acc_next;
    logic [COL_W-1:0]        col_reg, col_next;
    logic [LCW-1:0]          cnt_reg, cnt_next;
    logic [ftlex_pkg::OPC_W-1:0] pend_reg, pend_next;

    mode_t                   cur_mode;
    logic [VALUE_BITS-1:0]   cur_acc;
    logic [COL_W-1:0]        cur_col;
    logic [LCW-1:0]          cur_cnt;
    logic [ftlex_pkg::OPC_W-1:0] cur_pend;

    cls_t                    cls;
    logic [ftlex_pkg::OPC_W-1:0] opc;
    logic [3:0]              dval;
    logic [4:0]              lval;
    logic [VALUE_BITS+3:0]   acc_wide;
    logic [VALUE_BITS-1:0]   acc_digit;
    logic [COL_W+5:0]        col_wide;
    logic [COL_W-1:0]        col_letter;
    logic [COL_W-1:0]        col_first;

    // Outcome of handling the character as at the start of a token.
    mode_t                   b_mode;
    logic [VALUE_BITS-1:0]   b_acc;
    logic [COL_W-1:0]        b_col;
    logic [LCW-1:0]          b_cnt;
    logic [ftlex_pkg::OPC_W-1:0] b_pend;
    logic                    b_has_tok;
    ftlex_pkg::token_req_t   b_tok;

    ftlex_pkg::token_req_t   tok_a, tok_b;
    logic [1:0]              tok_n;

    function automatic ftlex_pkg::token_req_t make_tok(
        input logic [ftlex_pkg::KIND_W-1:0] kind,
        input logic [ftlex_pkg::TOKEN_VAL_W-1:0] val,
        input logic [ftlex_pkg::COL_W-1:0] col,
        input logic [ftlex_pkg::OPC_W-1:0] op
    );
        ftlex_pkg::token_req_t t;
        t.token_kind    = kind;
        t.token_value   = val;
        t.column_number = col;
        t.operator_code = op;
        t.last          = 1'b0;
        return t;
    endfunction

    // A restart request sees the lexer in its reset state.
    always_comb
    begin
        if (req.restart)
        begin
            cur_mode = MODE_START;
            cur_acc  = '0;
            cur_col  = '0;
            cur_cnt  = '0;
            cur_pend = '0;
        end
        else
        begin
            cur_mode = mode_reg;
            cur_acc  = acc_reg;
            cur_col  = col_reg;
            cur_cnt  = cnt_reg;
            cur_pend = pend_reg;
        end
    end

    always_comb
    begin
        opc = ftlex_pkg::OPC_PLUS;
        if (req.char_code >= 8'd65 && req.char_code <= 8'd90)
        begin
            cls = CLS_LETTER;
        end
        else if (req.char_code >= 8'd48 && req.char_code <= 8'd57)
        begin
            cls = CLS_DIGIT;
        end
        else
        begin
            unique case (req.char_code)
                8'h2B:
                begin
                    cls = CLS_OPER;
                    opc = ftlex_pkg::OPC_PLUS;
                end
                8'h2D:
                begin
                    cls = CLS_OPER;
                    opc = ftlex_pkg::OPC_MINUS;
                end
                8'h2A:
                begin
                    cls = CLS_OPER;
                    opc = ftlex_pkg::OPC_TIMES;
                end
                8'h2F:
                begin
                    cls = CLS_OPER;
                    opc = ftlex_pkg::OPC_DIV;
                end
                8'h28:
                begin
                    cls = CLS_OPER;
                    opc = ftlex_pkg::OPC_OPEN;
                end
                8'h29:
                begin
                    cls = CLS_OPER;
                    opc = ftlex_pkg::OPC_CLOSE;
                end
                8'h20, 8'h09: cls = CLS_SPACE;
                8'h00:        cls = CLS_ZERO;
                default:      cls = CLS_OTHER;
            endcase
        end
    end

    assign dval = 4'(req.char_code - 8'd48);
    assign lval = 5'(req.char_code - 8'd64);

    // acc * 10 + digit, saturating at the all-ones value.
    assign acc_wide  = {1'b0, cur_acc, 3'b000} + {3'b000, cur_acc, 1'b0}
                     + (VALUE_BITS+4)'(dval);
    assign acc_digit = (acc_wide[VALUE_BITS+3:VALUE_BITS] != 4'd0) ? '1
                     : acc_wide[VALUE_BITS-1:0];

    // col * 26 + letter, saturating at the all-ones value.
    assign col_wide   = {2'b00, cur_col, 4'b0000} + {3'b000, cur_col, 3'b000}
                      + {5'b00000, cur_col, 1'b0} + (COL_W+6)'(lval);
    assign col_letter = (col_wide[COL_W+5:COL_W] != 6'd0) ? '1 : col_wide[COL_W-1:0];
    assign col_first  = COL_W'(lval);

    always_comb
    begin
        b_mode    = cur_mode;
        b_acc     = cur_acc;
        b_col     = cur_col;
        b_cnt     = cur_cnt;
        b_pend    = cur_pend;
        b_has_tok = 1'b0;
        b_tok     = make_tok(ftlex_pkg::KIND_ERR, '0, '0, '0);
        unique case (cls)
            CLS_LETTER:
            begin
                b_col  = col_first;
                b_cnt  = LCW'(1);
                b_acc  = '0;
                b_mode = MODE_LETTERS;
            end
            CLS_DIGIT:
            begin
                b_acc  = VALUE_BITS'(dval);
                b_mode = MODE_NUMBER;
            end
            CLS_OPER:
            begin
                b_pend = opc;
                b_mode = MODE_OPER;
            end
            CLS_SPACE:
            begin
                b_mode = MODE_START;
            end
            CLS_ZERO:
            begin
                b_has_tok = 1'b1;
                b_tok     = make_tok(ftlex_pkg::KIND_END, '0, '0, '0);
                b_mode    = MODE_DONE;
            end
            default:
            begin
                b_has_tok = 1'b1;
                b_mode    = MODE_DONE;
            end
        endcase
    end

    always_comb
    begin
        mode_next = cur_mode;
        acc_next  = cur_acc;
        col_next  = cur_col;
        cnt_next  = cur_cnt;
        pend_next = cur_pend;
        tok_n     = 2'd0;
        tok_a     = b_tok;
        tok_b     = b_tok;
        unique case (cur_mode)
            MODE_START:
            begin
                mode_next = b_mode;
                acc_next  = b_acc;
                col_next  = b_col;
                cnt_next  = b_cnt;
                pend_next = b_pend;
                tok_n     = {1'b0, b_has_tok};
            end
            MODE_NUMBER:
            begin
                if (cls == CLS_DIGIT)
                begin
                    acc_next = acc_digit;
                end
                else
                begin
                    mode_next = b_mode;
                    acc_next  = b_acc;
                    col_next  = b_col;
                    cnt_next  = b_cnt;
                    pend_next = b_pend;
                    tok_a     = make_tok(ftlex_pkg::KIND_INT,
                                         ftlex_pkg::TOKEN_VAL_W'(cur_acc), '0, '0);
                    tok_n     = b_has_tok ? 2'd2 : 2'd1;
                end
            end
            MODE_LETTERS:
            begin
                if (cls == CLS_LETTER && cur_cnt < LCW'(MAX_COL_LETTERS))
                begin
                    col_next = col_letter;
                    cnt_next = cur_cnt + LCW'(1);
                end
                else if (cls == CLS_DIGIT)
                begin
                    acc_next  = VALUE_BITS'(dval);
                    mode_next = MODE_ROW;
                end
                else
                begin
                    tok_a     = make_tok(ftlex_pkg::KIND_ERR, '0, '0, '0);
                    tok_n     = 2'd1;
                    mode_next = MODE_DONE;
                end
            end
            MODE_ROW:
            begin
                if (cls == CLS_DIGIT)
                begin
                    acc_next = acc_digit;
                end
                else if (cls == CLS_OPER || cls == CLS_SPACE || cls == CLS_ZERO)
                begin
                    mode_next = b_mode;
                    acc_next  = b_acc;
                    col_next  = b_col;
                    cnt_next  = b_cnt;
                    pend_next = b_pend;
                    tok_a     = make_tok(ftlex_pkg::KIND_CELL,
                                         ftlex_pkg::TOKEN_VAL_W'(cur_acc), cur_col, '0);
                    tok_n     = b_has_tok ? 2'd2 : 2'd1;
                end
                else
                begin
                    tok_a     = make_tok(ftlex_pkg::KIND_ERR, '0, '0, '0);
                    tok_n     = 2'd1;
                    mode_next = MODE_DONE;
                end
            end
            MODE_OPER:
            begin
                mode_next = b_mode;
                acc_next  = b_acc;
                col_next  = b_col;
                cnt_next  = b_cnt;
                pend_next = b_pend;
                tok_a     = make_tok(ftlex_pkg::KIND_OPER, '0, '0, cur_pend);
                tok_n     = b_has_tok ? 2'd2 : 2'd1;
            end
            default:
            begin
                mode_next = cur_mode;
            end
        endcase
    end

    always_comb
    begin
        push.count  = step ? tok_n : 2'd0;
        push.first  = tok_a;
        push.second = tok_b;
        push.first.last  = (tok_n == 2'd1);
        push.second.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_START;
            acc_reg  <= '0;
            col_reg  <= '0;
            cnt_reg  <= '0;
            pend_reg <= '0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            col_reg  <= col_next;
            cnt_reg  <= cnt_next;
            pend_reg <= pend_next;
        end
    end

    // Once finished, only a restart brings tokens again.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && mode_reg == MODE_DONE && !req.restart) |-> (push.count == 2'd0))
        else $error("ftlex_core: token emitted after end or error");

    // While collecting letters the count stays between one and the limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_LETTERS) |->
            (cnt_reg != '0 && cnt_reg <= LCW'(MAX_COL_LETTERS)))
        else $error("ftlex_core: letter count out of range");

    // The first of two tokens is always a finished value or operator.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |->
            (push.first.token_kind == ftlex_pkg::KIND_INT
             || push.first.token_kind == ftlex_pkg::KIND_CELL
             || push.first.token_kind == ftlex_pkg::KIND_OPER))
        else $error("ftlex_core: bad leading token in a pair");

endmodule

@@ hw/rtl/ftlex_fifo.sv @@
`timescale 1ns / 1ps

module ftlex_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ftlex_pkg::token_push_t  push,
    output logic                    room,
    output logic                    token_valid,
    input  logic                    token_stall,
    output ftlex_pkg::token_req_t   token_req
);

    localparam int DEPTH = ftlex_pkg::RESULT_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ftlex_pkg::token_req_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;
    logic [PTR_W-1:0] wr_ptr_second;

    assign pop           = token_valid && !token_stall;
    assign token_valid   = (count_reg != '0);
    assign token_req     = mem[rd_ptr_reg];
    // Room for a full pair of tokens, independent of this cycle's pop.
    assign room          = (count_reg <= CNT_W'(DEPTH - 2));
    assign wr_ptr_second = wr_ptr_reg + PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_second] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("ftlex_fifo: result queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> room)
        else $error("ftlex_fifo: push without room");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("ftlex_fifo: pointers disagree on empty queue");

endmodule
